/* rtl/utf8_to_ucs2_decoder_defines.svh */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_DEFINES_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define U2U_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define U2U_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/u2u_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Shared types, byte-class constants and queue sizing.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Byte classification masks and patterns.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT   = 8'hE0;

  // Hebrew block bounds.
  localparam logic [15:0] HEBREW_LO = 16'h0590;
  localparam logic [15:0] HEBREW_HI = 16'h05FF;

  // Capacity register reset value.
  localparam logic [15:0] MAX_UNITS_RST = 16'd64;

  // Register file layout.
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic        REG_MAX_UNITS = 1'b0;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Sequence progress of the decoder.
  typedef enum logic [3:0] {
    PEND_NONE    = 4'b0001,
    PEND_TWO     = 4'b0010,
    PEND_THREE_A = 4'b0100,
    PEND_THREE_B = 4'b1000
  } pend_e;

  // One queued work entry: an optional code unit followed by an optional end result.
  typedef struct packed {
    logic        has_unit;
    logic [15:0] unit;
    logic        eos;
    logic        heb;
  } qent_t;

endpackage

/* rtl/u2u_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder front end
// Classifies each accepted byte, tracks the pending sequence and pushes work.
// ----------------------------------------------------------------------------
module u2u_front
  import u2u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] max_units_i,
  output logic        push_o,
  output qent_t       entry_o
);

  pend_e       pend_q, pend_d;
  logic [7:0]  lead_q, lead_d;
  logic [7:0]  second_q, second_d;
  logic [15:0] units_q, units_d;
  logic        heb_q, heb_d;

  logic [15:0] limit;
  logic        room;
  logic [15:0] cp2;
  logic [15:0] cp3;
  logic        produce;
  qent_t       entry;

  // Unit budget for the string; a zero capacity behaves like one.
  assign limit = (max_units_i == 16'd0) ? 16'd0 : max_units_i - 16'd1;
  assign room  = units_q < limit;

  // Code point assembly for two- and three-byte sequences.
  assign cp2 = {5'd0, lead_q[4:0], data_byte_i[5:0]};
  assign cp3 = {lead_q[3:0], second_q[5:0], data_byte_i[5:0]};

  // Next-state and work entry decode for one byte.
  always_comb begin
    pend_d   = pend_q;
    lead_d   = lead_q;
    second_d = second_q;
    units_d  = units_q;
    heb_d    = heb_q;
    produce  = 1'b0;
    entry    = '0;
    if (data_byte_i == 8'd0) begin
      // Terminator: flush a waiting ASCII middle byte, then the end result.
      produce        = 1'b1;
      entry.has_unit = (pend_q == PEND_THREE_B) && (second_q < ASCII_LIMIT) && room;
      entry.unit     = {8'd0, second_q};
      entry.eos      = 1'b1;
      entry.heb      = heb_q;
      pend_d         = PEND_NONE;
      lead_d         = '0;
      second_d       = '0;
      units_d        = '0;
      heb_d          = 1'b0;
    end else if (room) begin
      case (pend_q)
        PEND_TWO: begin
          produce        = 1'b1;
          entry.has_unit = 1'b1;
          entry.unit     = cp2;
          units_d        = units_q + 16'd1;
          pend_d         = PEND_NONE;
          if ((cp2 >= HEBREW_LO) && (cp2 <= HEBREW_HI)) begin
            heb_d = 1'b1;
          end
        end
        PEND_THREE_A: begin
          second_d = data_byte_i;
          pend_d   = PEND_THREE_B;
        end
        PEND_THREE_B: begin
          produce        = 1'b1;
          entry.has_unit = 1'b1;
          entry.unit     = cp3;
          units_d        = units_q + 16'd1;
          pend_d         = PEND_NONE;
        end
        default: begin
          if (data_byte_i < ASCII_LIMIT) begin
            produce        = 1'b1;
            entry.has_unit = 1'b1;
            entry.unit     = {8'd0, data_byte_i};
            units_d        = units_q + 16'd1;
          end else if ((data_byte_i & LEAD2_MASK) == LEAD2_PAT) begin
            lead_d = data_byte_i;
            pend_d = PEND_TWO;
          end else if ((data_byte_i & LEAD3_MASK) == LEAD3_PAT) begin
            lead_d = data_byte_i;
            pend_d = PEND_THREE_A;
          end
        end
      endcase
    end
  end

  assign push_o  = accept_i && produce;
  assign entry_o = entry;

  // Decoder state, updated only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= PEND_NONE;
      lead_q   <= '0;
      second_q <= '0;
      units_q  <= '0;
      heb_q    <= 1'b0;
    end else if (accept_i) begin
      pend_q   <= pend_d;
      lead_q   <= lead_d;
      second_q <= second_d;
      units_q  <= units_d;
      heb_q    <= heb_d;
    end
  end

endmodule

/* rtl/u2u_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder work queue
// Small register FIFO that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module u2u_queue
  import u2u_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t wdata_i,
  input  logic  pop_i,
  output qent_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

  qent_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign rdata_o = mem_q[rd_ptr_q];

  // Occupancy tracking.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/u2u_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder back end
// Expands queued work into result beats through an output register.
// ----------------------------------------------------------------------------
module u2u_back
  import u2u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qent_t       head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        end_of_string_o,
  output logic        hebrew_seen_o
);

  logic        valid_q, valid_d;
  logic [15:0] unit_q, unit_d;
  logic        eos_q, eos_d;
  logic        heb_q, heb_d;
  logic        eos_pend_q, eos_pend_d;
  logic        eos_heb_q, eos_heb_d;
  logic        load;

  // The output register takes a new beat when empty or being drained.
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !eos_pend_q && !empty_i;

  // Select the next result: a held end result first, then the queue head.
  always_comb begin
    valid_d    = valid_q;
    unit_d     = unit_q;
    eos_d      = eos_q;
    heb_d      = heb_q;
    eos_pend_d = eos_pend_q;
    eos_heb_d  = eos_heb_q;
    if (load) begin
      valid_d = 1'b0;
      if (eos_pend_q) begin
        valid_d    = 1'b1;
        unit_d     = '0;
        eos_d      = 1'b1;
        heb_d      = eos_heb_q;
        eos_pend_d = 1'b0;
      end else if (!empty_i) begin
        valid_d = 1'b1;
        if (head_i.has_unit) begin
          unit_d     = head_i.unit;
          eos_d      = 1'b0;
          heb_d      = 1'b0;
          eos_pend_d = head_i.eos;
          eos_heb_d  = head_i.heb;
        end else begin
          unit_d = '0;
          eos_d  = head_i.eos;
          heb_d  = head_i.heb;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      eos_pend_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      eos_pend_q <= eos_pend_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    unit_q    <= unit_d;
    eos_q     <= eos_d;
    heb_q     <= heb_d;
    eos_heb_q <= eos_heb_d;
  end

  assign out_valid_o     = valid_q;
  assign code_unit_o     = unit_q;
  assign end_of_string_o = eos_q;
  assign hebrew_seen_o   = heb_q;

endmodule

/* rtl/utf8_to_ucs2_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder
// Streams UTF-8 bytes in and 16-bit code units plus an end result out.
// ----------------------------------------------------------------------------
// The decoder accepts one byte per clock whenever its four-entry work queue
// has room, and delivers one result beat per clock while the sink does not
// stall. A zero byte closes the string and yields an end result (code unit
// zero, with the Hebrew flag), preceded by one flushed unit when a
// three-byte sequence was cut short after an ASCII middle byte; that
// terminator then yields both beats. A result reaches the output through
// the work queue and the output register: its byte is decoded into the
// queue at the accepting edge, and the output register loads it from the
// queue head. The capacity register max_units sits at byte address 0 of
// the APB port and should be written only while the decoder is idle.
`include "utf8_to_ucs2_decoder_defines.svh"

module utf8_to_ucs2_decoder
  import u2u_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        code_unit_o,
  output logic               end_of_string_o,
  output logic               hebrew_seen_o
);

  logic [15:0] max_units_q;
  logic        reg_sel;
  logic        accept;
  logic        push;
  qent_t       push_entry;
  qent_t       head;
  logic        pop;
  logic        q_empty;
  logic        q_full;

  // Register decode and capacity register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_MAX_UNITS);
  assign prdata  = reg_sel ? {{(PDATA_W-16){1'b0}}, max_units_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MAX_UNITS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_units_q <= pwdata[15:0];
    end
  end

  // Input handshake.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  u2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .max_units_i (max_units_q),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  u2u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u2u_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_unit_o     (code_unit_o),
    .end_of_string_o (end_of_string_o),
    .hebrew_seen_o   (hebrew_seen_o)
  );

  // The queue never takes an entry while full and never pops while empty.
  `U2U_ASSERT_NOW(a_no_overflow, push, !q_full, "work queue overflow")
  `U2U_ASSERT_NOW(a_no_underflow, pop, !q_empty, "work queue underflow")
  // An end result always carries a zero code unit.
  `U2U_ASSERT_NOW(a_eos_zero, out_valid_o && end_of_string_o, code_unit_o == 16'd0,
                  "end result with nonzero code unit")
  // The Hebrew flag is reported only on an end result.
  `U2U_ASSERT_NOW(a_heb_on_eos, out_valid_o && !end_of_string_o, !hebrew_seen_o,
                  "Hebrew flag on a code unit result")
  // An accepted terminator always shows up as a queued entry.
  `U2U_ASSERT_NEXT(a_term_queued, accept && (data_byte_i == 8'd0), !q_empty,
                   "terminator produced no queue entry")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder testbench
// Feeds byte strings through the decoder under random idling on both sides,
// predicts every code unit and end result, and checks each result beat
// field by field. Capacity settings are changed between phases over APB.
// ----------------------------------------------------------------------------
module tb_top;
  import u2u_pkg::*;

  // Byte address of the capacity register.
  localparam logic [PADDR_W-1:0] MAX_UNITS_ADDR = '0;
  // Cycles a result may still be on its way once nothing is expected.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned RUN_LIMIT_NS  = 2_000_000;
  localparam int unsigned MAX_PRINTED   = 100;
  localparam logic [7:0]  STRING_END    = 8'h00;

  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
    logic        heb;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        code_unit_o;
  logic               end_of_string_o;
  logic               hebrew_seen_o;

  // Decoder state as the predictor sees it.
  logic [15:0] cap_units;
  logic [7:0]  seq_lead;
  logic [7:0]  seq_middle;
  pend_e       seq_phase;
  logic [15:0] string_units;
  logic        string_hebrew;

  result_t     pending_results[$];

  int unsigned error_count        = 0;
  int unsigned bytes_accepted     = 0;
  int unsigned results_seen       = 0;
  int unsigned strings_closed     = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned hold_request       = 0;
  bit          src_idle_on        = 1'b1;
  bit          sink_idle_on       = 1'b1;

  utf8_to_ucs2_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_unit_o    (code_unit_o),
    .end_of_string_o(end_of_string_o),
    .hebrew_seen_o  (hebrew_seen_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #(RUN_LIMIT_NS);
    $display("ERROR: run did not finish within %0d ns", RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] unit_budget();
    if (cap_units == 16'd0) begin
      return 16'd0;
    end
    return cap_units - 16'd1;
  endfunction

  task automatic clear_string_state();
    seq_lead      = '0;
    seq_middle    = '0;
    seq_phase     = PEND_NONE;
    string_units  = '0;
    string_hebrew = 1'b0;
  endtask

  task automatic expect_result(input logic [15:0] unit, input logic eos, input logic heb);
    result_t r;
    r.unit = unit;
    r.eos  = eos;
    r.heb  = heb;
    pending_results.push_back(r);
  endtask

  // Works out the results one accepted byte causes and advances the state.
  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] cp;
    cp = '0;
    if (b == STRING_END) begin
      // A three-byte sequence cut after an ASCII middle byte flushes that byte.
      if (seq_phase == PEND_THREE_B && seq_middle < ASCII_LIMIT &&
          string_units < unit_budget()) begin
        expect_result({8'h00, seq_middle}, 1'b0, 1'b0);
      end
      expect_result(16'h0000, 1'b1, string_hebrew);
      clear_string_state();
    end else if (string_units < unit_budget()) begin
      case (seq_phase)
        PEND_TWO: begin
          cp = {5'b0, seq_lead[4:0], b[5:0]};
          if (cp >= HEBREW_LO && cp <= HEBREW_HI) begin
            string_hebrew = 1'b1;
          end
          expect_result(cp, 1'b0, 1'b0);
          string_units++;
          seq_phase = PEND_NONE;
        end
        PEND_THREE_A: begin
          seq_middle = b;
          seq_phase  = PEND_THREE_B;
        end
        PEND_THREE_B: begin
          cp = {seq_lead[3:0], seq_middle[5:0], b[5:0]};
          expect_result(cp, 1'b0, 1'b0);
          string_units++;
          seq_phase = PEND_NONE;
        end
        default: begin
          if (b < ASCII_LIMIT) begin
            expect_result({8'h00, b}, 1'b0, 1'b0);
            string_units++;
          end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            seq_lead  = b;
            seq_phase = PEND_TWO;
          end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            seq_lead  = b;
            seq_phase = PEND_THREE_A;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result unit=%h eos=%b heb=%b",
                                  code_unit_o, end_of_string_o, hebrew_seen_o));
      end else begin
        want = pending_results.pop_front();
        if (want.eos) begin
          strings_closed++;
        end
        if (code_unit_o !== want.unit) begin
          report_mismatch($sformatf("code_unit %h, expected %h", code_unit_o, want.unit));
        end
        if (end_of_string_o !== want.eos) begin
          report_mismatch($sformatf("end_of_string %b, expected %b",
                                    end_of_string_o, want.eos));
        end
        if (hebrew_seen_o !== want.heb) begin
          report_mismatch($sformatf("hebrew_seen %b, expected %b", hebrew_seen_o, want.heb));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && sink_idle_on) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 17) begin
          stall_left = $urandom_range(10, 40);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source and configuration access
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!src_idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offers one byte and returns at the edge where the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    bytes_accepted++;
    predict_byte(b);
  endtask

  task automatic send_bytes(input logic [7:0] list[$]);
    foreach (list[i]) begin
      send_byte(list[i]);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_UNITS_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_capacity_reg(input logic [15:0] want);
    logic [PDATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[15:0] !== want) begin
      report_mismatch($sformatf("max_units reads %h, expected %h", rdata[15:0], want));
    end
  endtask

  // Stops the source and waits until every expected result is out.
  task automatic wait_for_drain();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      pending_results.delete();
    end
  endtask

  task automatic set_capacity(input logic [15:0] value);
    logic [PDATA_W-1:0] rdata;
    wait_for_drain();
    apb_access(1'b1, {16'h0000, value}, rdata);
    cap_units = value;
    check_capacity_reg(value);
  endtask

  // ---------------------------------------------------------------------------
  // Random string generation
  // ---------------------------------------------------------------------------

  // Mostly a proper continuation byte, sometimes any nonzero byte.
  function automatic logic [7:0] follow_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) != 0) begin
      b = 8'h80 | 8'($urandom_range(0, 63));
    end else begin
      b = 8'($urandom_range(1, 255));
    end
    return b;
  endfunction

  task automatic send_random_string(input int unsigned max_chars);
    int unsigned n_chars;
    int unsigned kind;
    int unsigned c;
    logic [7:0]  b;
    n_chars = $urandom_range(0, max_chars);
    for (c = 0; c < n_chars; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        b = 8'($urandom_range(1, 127));
        send_byte(b);
      end else if (kind < 55) begin
        b = 8'hC0 | 8'($urandom_range(0, 31));
        send_byte(b);
        send_byte(follow_byte());
      end else if (kind < 65) begin
        // Two-byte code points around the Hebrew block.
        b = 8'($urandom_range(8'hD5, 8'hD8));
        send_byte(b);
        send_byte(follow_byte());
      end else if (kind < 80) begin
        b = 8'hE0 | 8'($urandom_range(0, 15));
        send_byte(b);
        send_byte(follow_byte());
        send_byte(follow_byte());
      end else if (kind < 90) begin
        // Four-byte leads, stray continuations and other junk.
        b = 8'($urandom_range(128, 255));
        send_byte(b);
      end else begin
        // A sequence broken off by whatever comes next.
        b = 8'($urandom_range(8'hC0, 8'hEF));
        send_byte(b);
      end
    end
    // Sometimes the string ends inside a sequence.
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      b = 8'hE0 | 8'($urandom_range(0, 15));
      send_byte(b);
      if ($urandom_range(0, 9) < 7) begin
        b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 127)) : follow_byte();
        send_byte(b);
      end
    end else if (kind < 18) begin
      b = 8'hC0 | 8'($urandom_range(0, 31));
      send_byte(b);
    end
    send_byte(STRING_END);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    check_capacity_reg(MAX_UNITS_RST);
  endtask

  // Field extremes, Hebrew bounds, dropped bytes and cut-off sequences.
  task automatic test_directed_bytes();
    send_bytes('{8'h01, 8'h7F, 8'hD6, 8'h90, STRING_END,
                 8'hD6, 8'h8F, 8'hEF, 8'hBF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                 8'hF0, 8'h80, 8'hFF, 8'hC3, 8'h41, STRING_END,
                 8'hD7, 8'hBF, 8'hE2, 8'h41, STRING_END,
                 8'hE2, 8'hC3, STRING_END,
                 8'hC3, STRING_END,
                 STRING_END});
  endtask

  task automatic test_capacity_limits();
    set_capacity(16'd1);
    send_bytes('{8'h41, 8'hC3, 8'hA9, STRING_END, 8'hE2, 8'h41, STRING_END});
    set_capacity(16'd0);
    send_bytes('{8'h41, STRING_END});
    set_capacity(16'd2);
    send_bytes('{8'h41, 8'h42, STRING_END, 8'hE2, 8'h41, STRING_END});
    set_capacity(16'd3);
    send_bytes('{8'h41, 8'hE2, 8'h42, STRING_END,
                 8'h41, 8'h42, 8'hE2, 8'h43, STRING_END});
  endtask

  // The sink holds off for a long stretch while bytes keep coming.
  task automatic test_input_backpressure();
    int unsigned i;
    set_capacity(16'hFFFF);
    src_idle_on  = 1'b0;
    hold_request = 120;
    for (i = 0; i < 20; i++) begin
      send_bytes('{8'($urandom_range(1, 127)), 8'hD7, 8'h90});
    end
    send_byte(STRING_END);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_strings();
    int unsigned phase;
    int unsigned phase_start;
    int unsigned max_chars;
    logic [15:0] cap;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: cap = MAX_UNITS_RST;
        1: cap = 16'hFFFF;
        2: cap = 16'd1;
        3: cap = 16'd7;
        4: cap = 16'd0;
        5: cap = 16'd20;
        6: cap = 16'd2;
        7: cap = 16'($urandom_range(1, 40));
        8: cap = 16'd3;
        default: cap = 16'hFFFF;
      endcase
      set_capacity(cap);
      // Some phases run without any idling at all.
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      max_chars    = (cap > 16'd100) ? 40 : 14;
      phase_start  = bytes_accepted;
      while (bytes_accepted < phase_start + 105) begin
        if ($urandom_range(0, 19) == 0) begin
          // Pure noise string over the whole byte range.
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)));
          send_byte(STRING_END);
        end else begin
          send_random_string(max_chars);
        end
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cap_units   = MAX_UNITS_RST;
    clear_string_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_bytes();
    test_capacity_limits();
    test_input_backpressure();
    test_random_strings();
    wait_for_drain();

    $display("Decoded %0d bytes into %0d result beats over %0d strings.",
             bytes_accepted, results_seen, strings_closed);
    $display("Input was held back for %0d cycles; %0d mismatches found.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/u2u_pkg.sv
rtl/u2u_front.sv
rtl/u2u_queue.sv
rtl/u2u_back.sv
rtl/utf8_to_ucs2_decoder.sv
sim/tb_top.sv
